// ===== design/sgss_pkg.sv =====
// ----------------------------------------------------------------------------
// sgss_pkg
// Shared types and constants of the sequential gear shift sequencer: request
// and response words, configuration set, gear codes and reset values.
// ----------------------------------------------------------------------------
package sgss_pkg;

   localparam int GEAR_W = 4;
   localparam int CFG_W  = 16;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 5;

   typedef logic signed [GEAR_W-1:0] gear_type;
   typedef logic [CFG_W-1:0]         cfg_time_type;

   localparam gear_type GEAR_FIRST   = -4'sd1;
   localparam gear_type GEAR_NEUTRAL = 4'sd0;
   localparam gear_type GEAR_SECOND  = 4'sd1;

   typedef struct packed {
      logic up_button_n;
      logic down_button_n;
      logic neutral_button_n;
   } req_word_type;

   typedef struct packed {
      logic                     key_one;
      logic                     key_two;
      logic                     ignition_kill;
      logic signed [GEAR_W-1:0] gear;
      logic                     store_strobe;
      logic                     busy_res;
   } rsp_word_type;

   typedef struct packed {
      gear_type     start_gear;
      cfg_time_type shift_hold;
      cfg_time_type neutral_hold;
      cfg_time_type kill_overlap;
      cfg_time_type kill_tail;
      cfg_time_type settle;
      cfg_time_type return_pulse;
      cfg_time_type poll;
   } cfg_type;

   localparam gear_type     RST_START_GEAR   = 4'sd0;
   localparam cfg_time_type RST_SHIFT_HOLD   = 16'd120;
   localparam cfg_time_type RST_NEUTRAL_HOLD = 16'd40;
   localparam cfg_time_type RST_KILL_OVERLAP = 16'd80;
   localparam cfg_time_type RST_KILL_TAIL    = 16'd20;
   localparam cfg_time_type RST_SETTLE       = 16'd200;
   localparam cfg_time_type RST_RETURN_PULSE = 16'd50;
   localparam cfg_time_type RST_POLL         = 16'd50;

endpackage

// ===== design/sgss_csr.sv =====
// ----------------------------------------------------------------------------
// sgss_csr
// Configuration register file behind an APB-style port. Clamps the start gear
// on write and signals a gear load to the sequencer core.
// ----------------------------------------------------------------------------
module sgss_csr #(
   parameter int TOP_GEAR = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sgss_pkg::ADDR_W-1:0]   paddr,
   input  logic [sgss_pkg::DATA_W-1:0]   pwdata,
   output logic [sgss_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output sgss_pkg::cfg_type             cfg,
   output logic                          gear_load,
   output sgss_pkg::gear_type            gear_init
);

   localparam logic [2:0] REG_START_GEAR   = 3'd0;
   localparam logic [2:0] REG_SHIFT_HOLD   = 3'd1;
   localparam logic [2:0] REG_NEUTRAL_HOLD = 3'd2;
   localparam logic [2:0] REG_KILL_OVERLAP = 3'd3;
   localparam logic [2:0] REG_KILL_TAIL    = 3'd4;
   localparam logic [2:0] REG_SETTLE       = 3'd5;
   localparam logic [2:0] REG_RETURN_PULSE = 3'd6;
   localparam logic [2:0] REG_POLL         = 3'd7;

   localparam sgss_pkg::gear_type TopGear = sgss_pkg::GEAR_W'(TOP_GEAR);

   sgss_pkg::cfg_type  cfg_ff, cfg_in;
   sgss_pkg::gear_type wr_gear;
   sgss_pkg::gear_type clamp_gear;
   logic [2:0]         reg_index;
   logic               wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_en     = psel && penable && pwrite;
   assign wr_gear   = $signed(pwdata[sgss_pkg::GEAR_W-1:0]);

   always_comb begin
      clamp_gear = wr_gear;
      if (wr_gear < sgss_pkg::GEAR_FIRST) begin
         clamp_gear = sgss_pkg::GEAR_FIRST;
      end else if (wr_gear > TopGear) begin
         clamp_gear = TopGear;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_START_GEAR:   cfg_in.start_gear   = clamp_gear;
            REG_SHIFT_HOLD:   cfg_in.shift_hold   = pwdata[sgss_pkg::CFG_W-1:0];
            REG_NEUTRAL_HOLD: cfg_in.neutral_hold = pwdata[sgss_pkg::CFG_W-1:0];
            REG_KILL_OVERLAP: cfg_in.kill_overlap = pwdata[sgss_pkg::CFG_W-1:0];
            REG_KILL_TAIL:    cfg_in.kill_tail    = pwdata[sgss_pkg::CFG_W-1:0];
            REG_SETTLE:       cfg_in.settle       = pwdata[sgss_pkg::CFG_W-1:0];
            REG_RETURN_PULSE: cfg_in.return_pulse = pwdata[sgss_pkg::CFG_W-1:0];
            REG_POLL:         cfg_in.poll         = pwdata[sgss_pkg::CFG_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_gear   <= sgss_pkg::RST_START_GEAR;
         cfg_ff.shift_hold   <= sgss_pkg::RST_SHIFT_HOLD;
         cfg_ff.neutral_hold <= sgss_pkg::RST_NEUTRAL_HOLD;
         cfg_ff.kill_overlap <= sgss_pkg::RST_KILL_OVERLAP;
         cfg_ff.kill_tail    <= sgss_pkg::RST_KILL_TAIL;
         cfg_ff.settle       <= sgss_pkg::RST_SETTLE;
         cfg_ff.return_pulse <= sgss_pkg::RST_RETURN_PULSE;
         cfg_ff.poll         <= sgss_pkg::RST_POLL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_START_GEAR:   prdata = sgss_pkg::DATA_W'(signed'(cfg_ff.start_gear));
         REG_SHIFT_HOLD:   prdata = sgss_pkg::DATA_W'(cfg_ff.shift_hold);
         REG_NEUTRAL_HOLD: prdata = sgss_pkg::DATA_W'(cfg_ff.neutral_hold);
         REG_KILL_OVERLAP: prdata = sgss_pkg::DATA_W'(cfg_ff.kill_overlap);
         REG_KILL_TAIL:    prdata = sgss_pkg::DATA_W'(cfg_ff.kill_tail);
         REG_SETTLE:       prdata = sgss_pkg::DATA_W'(cfg_ff.settle);
         REG_RETURN_PULSE: prdata = sgss_pkg::DATA_W'(cfg_ff.return_pulse);
         REG_POLL:         prdata = sgss_pkg::DATA_W'(cfg_ff.poll);
         default:          prdata = '0;
      endcase
   end

   assign cfg       = cfg_ff;
   assign gear_load = wr_en && (reg_index == REG_START_GEAR);
   assign gear_init = clamp_gear;

endmodule

// ===== design/sgss_core.sv =====
// ----------------------------------------------------------------------------
// sgss_core
// Sequencer state and one-tick step logic: button sampling, gear stepping,
// pulse phase timing and the queued down shift.
// ----------------------------------------------------------------------------
module sgss_core #(
   parameter int TOP_GEAR    = 4,
   parameter int TIMER_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sgss_pkg::cfg_type      cfg,
   input  logic                   gear_load,
   input  sgss_pkg::gear_type     gear_init,
   input  logic                   step,
   input  sgss_pkg::req_word_type req_word,
   output sgss_pkg::rsp_word_type rsp_word
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_HOLD    = 3'd1;
   localparam logic [2:0] PH_OVERLAP = 3'd2;
   localparam logic [2:0] PH_TAIL    = 3'd3;
   localparam logic [2:0] PH_SETTLE  = 3'd4;
   localparam logic [2:0] PH_RETURN  = 3'd5;

   localparam sgss_pkg::gear_type TopGear = sgss_pkg::GEAR_W'(TOP_GEAR);

   typedef logic [TIMER_WIDTH-1:0] timer_type;

   typedef struct packed {
      logic [2:0] phase;
      timer_type  timer;
   } entry_type;

   typedef struct packed {
      logic signed [sgss_pkg::GEAR_W-1:0] gear;
      logic [2:0]                         phase;
      timer_type                          ptimer;
      timer_type                          poll;
      logic                               last_up;
      logic                               last_down;
      logic                               last_neutral;
      logic                               pending;
      logic                               shift_up;
      logic                               short_hold;
      logic                               strobe;
   } st_type;

   function automatic timer_type phase_len(input logic [2:0] ph, input logic shorth,
                                           input sgss_pkg::cfg_type c);
      timer_type v;
      case (ph)
         PH_HOLD:    v = shorth ? TIMER_WIDTH'(c.neutral_hold) : TIMER_WIDTH'(c.shift_hold);
         PH_OVERLAP: v = TIMER_WIDTH'(c.kill_overlap);
         PH_TAIL:    v = TIMER_WIDTH'(c.kill_tail);
         PH_SETTLE:  v = TIMER_WIDTH'(c.settle);
         PH_RETURN:  v = TIMER_WIDTH'(c.return_pulse);
         default:    v = '0;
      endcase
      return v;
   endfunction

   function automatic entry_type enter_phase(input logic [2:0] from, input logic shorth,
                                             input sgss_pkg::cfg_type c);
      entry_type e;
      logic      found;
      e.phase = PH_IDLE;
      e.timer = '0;
      found   = 1'b0;
      for (int p = 1; p <= 5; p++) begin
         if (!found && (3'(p) >= from) && (phase_len(3'(p), shorth, c) != '0)) begin
            found   = 1'b1;
            e.phase = 3'(p);
            e.timer = phase_len(3'(p), shorth, c);
         end
      end
      return e;
   endfunction

   function automatic st_type start_seq(input st_type s_in, input logic up,
                                        input logic shorth, input sgss_pkg::cfg_type c);
      st_type    s;
      entry_type e;
      s            = s_in;
      s.shift_up   = up;
      s.short_hold = shorth;
      e            = enter_phase(PH_HOLD, shorth, c);
      s.phase      = e.phase;
      s.ptimer     = e.timer;
      if ((e.phase == PH_IDLE) && shorth) begin
         s.gear       = sgss_pkg::GEAR_NEUTRAL;
         s.strobe     = 1'b1;
         s.short_hold = 1'b0;
      end
      return s;
   endfunction

   function automatic st_type do_down(input st_type s_in, input sgss_pkg::cfg_type c);
      st_type s;
      s = s_in;
      if ($signed(s.gear) > sgss_pkg::GEAR_FIRST) begin
         s.gear   = ($signed(s.gear) == sgss_pkg::GEAR_SECOND) ? sgss_pkg::GEAR_FIRST
                                                              : $signed(s.gear) - 4'sd1;
         s.strobe = 1'b1;
         s        = start_seq(s, 1'b0, 1'b0, c);
      end
      return s;
   endfunction

   st_type    st_ff, st_in;
   st_type    s;
   entry_type nxt;
   logic      pu, pd, pn;
   logic      first_on, other_on;
   logic      k1, k2, kill, busy;

   assign pu = !req_word.up_button_n;
   assign pd = !req_word.down_button_n;
   assign pn = !req_word.neutral_button_n;

   always_comb begin
      s        = st_ff;
      s.strobe = 1'b0;
      nxt      = '0;
      first_on = 1'b0;
      other_on = 1'b0;
      k1       = 1'b0;
      k2       = 1'b0;
      kill     = 1'b0;
      busy     = 1'b0;
      // sample buttons once the poll wait has run out
      if (s.phase == PH_IDLE) begin
         if (s.poll != '0) begin
            s.poll = s.poll - 1'b1;
         end else if (pn != s.last_neutral) begin
            s.last_neutral = pn;
            if (pn) begin
               if ($signed(s.gear) == sgss_pkg::GEAR_FIRST) begin
                  s = start_seq(s, 1'b1, 1'b1, cfg);
               end else if ($signed(s.gear) == sgss_pkg::GEAR_SECOND) begin
                  s = start_seq(s, 1'b0, 1'b1, cfg);
               end
            end
            s.poll = '0;
         end else begin
            if (pu && !s.last_up && ($signed(s.gear) < TopGear)) begin
               s.gear   = ($signed(s.gear) == sgss_pkg::GEAR_FIRST) ? sgss_pkg::GEAR_SECOND
                                                                   : $signed(s.gear) + 4'sd1;
               s.strobe = 1'b1;
               s        = start_seq(s, 1'b1, 1'b0, cfg);
            end
            if (pd && !s.last_down) begin
               if (s.phase != PH_IDLE) begin
                  s.pending = 1'b1;
               end else begin
                  s = do_down(s, cfg);
               end
            end
            s.last_up   = pu;
            s.last_down = pd;
            s.poll      = TIMER_WIDTH'(cfg.poll);
         end
      end
      // advance the pulse sequence
      if (s.phase != PH_IDLE) begin
         first_on = (s.phase == PH_HOLD) || (s.phase == PH_OVERLAP);
         other_on = (s.phase == PH_RETURN);
         busy     = 1'b1;
         kill     = (s.phase == PH_OVERLAP) || (s.phase == PH_TAIL);
         k1       = s.shift_up ? first_on : other_on;
         k2       = s.shift_up ? other_on : first_on;
         s.ptimer = s.ptimer - 1'b1;
         if (s.ptimer == '0) begin
            nxt      = enter_phase(3'(s.phase + 3'd1), s.short_hold, cfg);
            s.phase  = nxt.phase;
            s.ptimer = nxt.timer;
            if (s.phase == PH_IDLE) begin
               if (s.short_hold) begin
                  s.gear       = sgss_pkg::GEAR_NEUTRAL;
                  s.strobe     = 1'b1;
                  s.short_hold = 1'b0;
               end
               if (s.pending) begin
                  s.pending = 1'b0;
                  s         = do_down(s, cfg);
               end
            end
         end
      end
      st_in = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{gear: sgss_pkg::RST_START_GEAR, default: '0};
      end else if (gear_load) begin
         st_ff.gear <= gear_init;
      end else if (step) begin
         st_ff <= st_in;
      end
   end

   assign rsp_word.key_one       = k1;
   assign rsp_word.key_two       = k2;
   assign rsp_word.ignition_kill = kill;
   assign rsp_word.gear          = st_in.gear;
   assign rsp_word.store_strobe  = st_in.strobe;
   assign rsp_word.busy_res      = busy;

   a_timer_live: assert property (@(posedge clock) disable iff (reset)
      (st_ff.phase != PH_IDLE) |-> (st_ff.ptimer != '0))
      else $error("active phase with expired timer");

   a_pending_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff.pending |-> (st_ff.phase != PH_IDLE))
      else $error("queued down shift without running sequence");

   a_short_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff.short_hold |-> (st_ff.phase != PH_IDLE))
      else $error("neutral move flag left while idle");

   a_gear_range: assert property (@(posedge clock) disable iff (reset)
      ($signed(st_ff.gear) >= sgss_pkg::GEAR_FIRST) && ($signed(st_ff.gear) <= TopGear))
      else $error("gear out of range");

endmodule

// ===== design/sequential_gear_shift_sequencer.sv =====
// ----------------------------------------------------------------------------
// sequential_gear_shift_sequencer
// Tick-driven gear shift sequencer: input word register, one-pass step logic
// and a registered response word.
// The step is one pass through the core logic between the two word registers.
// Throughput: one word per cycle while the response side is not stalled.
// Reset: synchronous, active high; clears valid flags and sequencer state,
// loads register defaults and gear 0.
// ----------------------------------------------------------------------------
module sequential_gear_shift_sequencer #(
   parameter int TOP_GEAR    = 4,
   parameter int TIMER_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sgss_pkg::req_word_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sgss_pkg::rsp_word_type        rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sgss_pkg::ADDR_W-1:0]   paddr,
   input  logic [sgss_pkg::DATA_W-1:0]   pwdata,
   output logic [sgss_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   sgss_pkg::cfg_type      cfg;
   logic                   gear_load;
   sgss_pkg::gear_type     gear_init;
   logic                   in_valid_ff;
   sgss_pkg::req_word_type in_word_ff;
   logic                   out_valid_ff;
   sgss_pkg::rsp_word_type out_word_ff;
   sgss_pkg::rsp_word_type step_word;
   logic                   advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   sgss_csr #(
      .TOP_GEAR (TOP_GEAR)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .cfg       (cfg),
      .gear_load (gear_load),
      .gear_init (gear_init)
   );

   sgss_core #(
      .TOP_GEAR    (TOP_GEAR),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .gear_load (gear_load),
      .gear_init (gear_init),
      .step      (advance),
      .req_word  (in_word_ff),
      .rsp_word  (step_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= step_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule
